// ===== design/owsr_pkg.sv =====
`default_nettype none

package owsr_pkg;

   // request kinds
   localparam logic [1:0] KIND_START      = 2'd0;
   localparam logic [1:0] KIND_RESET_DONE = 2'd1;
   localparam logic [1:0] KIND_BYTE       = 2'd2;

   // response actions
   localparam logic [2:0] ACT_RESET = 3'd0;
   localparam logic [2:0] ACT_WRITE = 3'd1;
   localparam logic [2:0] ACT_READ  = 3'd2;
   localparam logic [2:0] ACT_DONE  = 3'd3;
   localparam logic [2:0] ACT_NONE  = 3'd4;

   // configuration register indexes
   localparam logic CSR_MAX_ATTEMPTS    = 1'b0;
   localparam logic CSR_EXPECTED_FAMILY = 1'b1;

   localparam logic [3:0] MAX_ATTEMPTS_RESET    = 4'd4;
   localparam logic [7:0] EXPECTED_FAMILY_RESET = 8'd1;

   localparam logic [7:0] ROM_CMD  = 8'h33;
   localparam logic [7:0] CRC_POLY = 8'h8c;
   localparam logic [2:0] ID_BYTES = 3'd6;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PRESENCE = 3'd1,
      PH_FAMILY   = 3'd2,
      PH_ID       = 3'd3,
      PH_CRC      = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       presence;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  tx_byte;
      logic        success;
      logic [47:0] serial_number;
      logic        last;
   } rsp_type;

   // one or two responses handed from the core to the response queue
   typedef struct packed {
      logic    push;
      logic    two;
      rsp_type first;
      rsp_type second;
   } push_type;

endpackage

`default_nettype wire

// ===== design/owsr_core.sv =====
`default_nettype none

module owsr_core import owsr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       accept,
   input  wire req_type    req_data,
   output push_type        push
);

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] act, input logic [7:0] tx,
                                        input logic ok, input logic [47:0] sn,
                                        input logic lst);
      rsp_type r;
      r.action        = act;
      r.tx_byte       = tx;
      r.success       = ok;
      r.serial_number = sn;
      r.last          = lst;
      return r;
   endfunction

   logic [3:0]  max_attempts_ff;
   logic [7:0]  expected_family_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  attempts_left_ff, attempts_left_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic        attempt_bad_ff, attempt_bad_in;
   logic [2:0]  id_bytes_left_ff, id_bytes_left_in;
   logic [47:0] id_shift_ff, id_shift_in;

   logic [7:0]  crc_next;
   logic [3:0]  attempts_dec;
   logic [2:0]  id_left_dec;
   logic        crc_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff    <= MAX_ATTEMPTS_RESET;
         expected_family_ff <= EXPECTED_FAMILY_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_ATTEMPTS) begin
            max_attempts_ff <= csr_wdata[3:0];
         end else begin
            expected_family_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         attempts_left_ff <= '0;
         running_crc_ff   <= '0;
         attempt_bad_ff   <= 1'b0;
         id_bytes_left_ff <= '0;
         id_shift_ff      <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         attempts_left_ff <= attempts_left_in;
         running_crc_ff   <= running_crc_in;
         attempt_bad_ff   <= attempt_bad_in;
         id_bytes_left_ff <= id_bytes_left_in;
         id_shift_ff      <= id_shift_in;
      end
   end

   // family byte starts from a zero crc
   assign crc_next     = crc_step((phase_ff == PH_FAMILY) ? 8'h00 : running_crc_ff,
                                  req_data.rx_byte);
   assign attempts_dec = (attempts_left_ff == 4'd0) ? 4'd0 : attempts_left_ff - 4'd1;
   assign id_left_dec  = id_bytes_left_ff - 3'd1;
   assign crc_match    = !attempt_bad_ff && (running_crc_ff == req_data.rx_byte);

   always_comb begin
      phase_in         = phase_ff;
      attempts_left_in = attempts_left_ff;
      running_crc_in   = running_crc_ff;
      attempt_bad_in   = attempt_bad_ff;
      id_bytes_left_in = id_bytes_left_ff;
      id_shift_in      = id_shift_ff;
      push.push        = accept;
      push.two         = 1'b0;
      push.first       = make_rsp(ACT_NONE, 8'h00, 1'b0, 48'h0, 1'b1);
      push.second      = make_rsp(ACT_READ, 8'h00, 1'b0, 48'h0, 1'b1);

      if (req_data.kind == KIND_START) begin
         attempts_left_in = (max_attempts_ff == 4'd0) ? 4'd1 : max_attempts_ff;
         phase_in         = PH_PRESENCE;
         push.first       = make_rsp(ACT_RESET, 8'h00, 1'b0, 48'h0, 1'b1);
      end else begin
         unique case (phase_ff)
            PH_PRESENCE: begin
               if (req_data.kind == KIND_RESET_DONE) begin
                  running_crc_in   = '0;
                  id_shift_in      = '0;
                  id_bytes_left_in = '0;
                  if (req_data.presence) begin
                     attempt_bad_in = 1'b0;
                     phase_in       = PH_FAMILY;
                     push.two       = 1'b1;
                     push.first     = make_rsp(ACT_WRITE, ROM_CMD, 1'b0, 48'h0, 1'b0);
                  end else begin
                     // no device: still read one byte, which fails as the crc byte
                     attempt_bad_in = 1'b1;
                     phase_in       = PH_CRC;
                     push.first     = make_rsp(ACT_READ, 8'h00, 1'b0, 48'h0, 1'b1);
                  end
               end
            end
            PH_FAMILY: begin
               if (req_data.kind == KIND_BYTE) begin
                  running_crc_in = crc_next;
                  if (req_data.rx_byte == expected_family_ff) begin
                     id_bytes_left_in = ID_BYTES;
                     phase_in         = PH_ID;
                  end else begin
                     attempt_bad_in = 1'b1;
                     phase_in       = PH_CRC;
                  end
                  push.first = make_rsp(ACT_READ, 8'h00, 1'b0, 48'h0, 1'b1);
               end
            end
            PH_ID: begin
               if (req_data.kind == KIND_BYTE) begin
                  id_shift_in      = {id_shift_ff[39:0], req_data.rx_byte};
                  running_crc_in   = crc_next;
                  id_bytes_left_in = id_left_dec;
                  if (id_left_dec == 3'd0) begin
                     phase_in = PH_CRC;
                  end
                  push.first = make_rsp(ACT_READ, 8'h00, 1'b0, 48'h0, 1'b1);
               end
            end
            PH_CRC: begin
               if (req_data.kind == KIND_BYTE) begin
                  attempts_left_in = attempts_dec;
                  if (crc_match) begin
                     phase_in   = PH_IDLE;
                     push.first = make_rsp(ACT_DONE, 8'h00, 1'b1, id_shift_ff, 1'b1);
                  end else if (attempts_dec != 4'd0) begin
                     phase_in   = PH_PRESENCE;
                     push.first = make_rsp(ACT_RESET, 8'h00, 1'b0, 48'h0, 1'b1);
                  end else begin
                     phase_in   = PH_IDLE;
                     push.first = make_rsp(ACT_DONE, 8'h00, 1'b0, 48'h0, 1'b1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // an attempt in progress always has at least one attempt left
   a_attempts_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (attempts_left_ff != 4'd0))
      else $error("attempt in progress with no attempts left");

   // collecting id bytes always has some left
   a_id_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ID) |-> (id_bytes_left_ff != 3'd0))
      else $error("id phase with no bytes left");

   // a second response only follows a rom command write
   a_two_write: assert property (@(posedge clock) disable iff (reset)
      (push.push && push.two) |-> (push.first.action == ACT_WRITE && !push.first.last))
      else $error("second response without rom command");

endmodule

`default_nettype wire

// ===== design/owsr_rsp_queue.sv =====
`default_nettype none

module owsr_rsp_queue import owsr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   rsp_type    entries_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [2:0] n_push;

   assign room      = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = !push.push ? 3'd0 : (push.two ? 3'd2 : 3'd1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + n_push - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entries_ff[wr_ptr_ff] <= push.first;
         if (push.two) begin
            entries_ff[wr_ptr_ff + 2'd1] <= push.second;
         end
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("response queue over capacity");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.push |-> room)
      else $error("push without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/onewire_serial_id_reader_unit.sv =====
`default_nettype none

// 1-wire serial id reader: each request is one bus event (start, reset done with
// presence, or a received byte) and yields one or two responses telling the bus
// engine what to do next (reset, write the read-rom command, read a byte, or
// finished with the 48-bit id and a success flag). The whole update, including
// the unrolled crc-8 step, happens in the cycle a request is accepted, and the
// responses go into a four-entry response queue. A request is taken whenever the
// queue has at least two free entries, so one request per cycle is sustained while
// the response side keeps up; the response port drains one entry per cycle, which
// sets the long-run rate. Configuration writes take effect on the next cycle
// and are meant for idle periods.
module onewire_serial_id_reader_unit import owsr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration write port
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   // bus event requests
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   // bus engine responses
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   logic     accept;
   logic     room;
   push_type push;

   // room for the two responses a request can cause
   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   // phase machine, attempt counter, crc and id shift register
   owsr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push)
   );

   // response queue decouples the request side from a stalled response side
   owsr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // responses of one request end with last set
   a_last_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == ACT_DONE || rsp_data.action == ACT_RESET))
      |-> rsp_data.last)
      else $error("reset or done response without last");

   // serial number only reported on success
   a_sn_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.success) |-> (rsp_data.serial_number == 48'h0))
      else $error("serial number without success");

   // the request side only stalls while responses are waiting
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (!req_ready) |-> rsp_valid)
      else $error("request stalled while no response pending");

endmodule

`default_nettype wire
